// ----- rtl/dal_pkg.sv -----
package dal_pkg;

  // sizes of the record store and channel set
  localparam int RECORDS   = 64;
  localparam int CHANNELS  = 16;
  localparam int FRAC_BITS = 8;

  // field widths
  localparam int SLOT_W = 6;
  localparam int CH_W   = 4;
  localparam int NCH_W  = 5;
  localparam int TS_W   = 32;
  localparam int VAL_W  = 16;
  localparam int LS_W   = 17;
  localparam int LSUM_W = 48;
  localparam int PSUM_W = 32;
  localparam int UCNT_W = 16;
  localparam int AVG_W  = 25;
  localparam int PAVG_W = 16;
  localparam int IVL_W  = 17;
  localparam int RC_W   = 7;
  localparam int CFG_W  = 16;
  localparam int CFGI_W = 2;

  // record store geometry
  localparam int MEM_DEPTH = RECORDS * CHANNELS;
  localparam int MEM_AW    = SLOT_W + CH_W;
  localparam int MEM_DW    = AVG_W + PAVG_W;
  localparam int HALF_W    = SLOT_W - 1;

  // reset values
  localparam logic [NCH_W-1:0] CH_COUNT_RST  = NCH_W'(4);
  localparam logic [IVL_W-1:0] INIT_INTERVAL = IVL_W'(24);
  localparam logic [CFG_W-1:0] MAX_IVL_RST   = CFG_W'(43200);

  // register indexes
  localparam logic [CFGI_W-1:0] CFG_CHANNEL_COUNT = CFGI_W'(0);
  localparam logic [CFGI_W-1:0] CFG_MAX_INTERVAL  = CFGI_W'(2);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [TS_W-1:0]   timestamp;
    logic [CH_W-1:0]   channel;
    logic [LS_W-1:0]   lvl_ship;
    logic [VAL_W-1:0]  planet;
    logic              eou;
    logic [SLOT_W-1:0] read_slot;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   channel;
    logic [AVG_W-1:0]  level_avg;
    logic [PAVG_W-1:0] planet_avg;
    logic [RC_W-1:0]   records_used;
    logic [IVL_W-1:0]  interval;
    logic              last;
  } result_t;

endpackage

// ----- rtl/dal_front.sv -----
module dal_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        command_i,
  input  logic [dal_pkg::TS_W-1:0]    timestamp_i,
  input  logic [dal_pkg::CH_W-1:0]    channel_i,
  input  logic [dal_pkg::VAL_W-1:0]   level_value_i,
  input  logic [dal_pkg::VAL_W-1:0]   ship_count_i,
  input  logic [dal_pkg::VAL_W-1:0]   planet_count_i,
  input  logic                        end_of_update_i,
  input  logic [dal_pkg::SLOT_W-1:0]  read_slot_i,
  output logic                        valid_o,
  output dal_pkg::item_t              item_o,
  input  logic                        pop_i
);

  dal_pkg::item_t item;
  dal_pkg::item_t buf_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           wr_en, rd_en;

  // classify the word and fold level and ships together
  always_comb begin
    item.cmd       = command_i ? dal_pkg::CMD_READ : dal_pkg::CMD_SAMPLE;
    item.timestamp = timestamp_i;
    item.channel   = channel_i;
    item.lvl_ship  = dal_pkg::LS_W'(level_value_i) + dal_pkg::LS_W'(ship_count_i);
    item.planet    = planet_count_i;
    item.eou       = end_of_update_i;
    item.read_slot = read_slot_i;
  end

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rd_q];
  assign wr_en   = push && !full;
  assign rd_en   = pop_i && valid_o;

  // two-entry queue toward the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= !wr_q;
      if (rd_en) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_q] <= item;
  end

endmodule

// ----- rtl/dal_div.sv -----
module dal_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dal_pkg::LSUM_W-1:0]  lvl_sum_i,
  input  logic [dal_pkg::PSUM_W-1:0]  pln_sum_i,
  input  logic [dal_pkg::UCNT_W-1:0]  count_i,
  output logic                        done_o,
  output logic [dal_pkg::AVG_W-1:0]   lvl_avg_o,
  output logic [dal_pkg::PAVG_W-1:0]  pln_avg_o
);

  localparam int LD_W  = dal_pkg::LSUM_W + dal_pkg::FRAC_BITS;
  localparam int LHI_W = LD_W - dal_pkg::AVG_W;
  localparam int PHI_W = dal_pkg::PSUM_W - dal_pkg::PAVG_W;
  localparam int W     = dal_pkg::UCNT_W;
  localparam int STP_W = $clog2(dal_pkg::AVG_W);

  logic                        busy_q, done_q;
  logic [STP_W-1:0]            step_q;
  logic [W-1:0]                div_q;
  logic [W-1:0]                lrem_q, prem_q;
  logic [dal_pkg::AVG_W-1:0]   ldiv_q, lq_q;
  logic [dal_pkg::PAVG_W-1:0]  pdiv_q, pq_q;
  logic                        lsat_q, psat_q;
  logic [LD_W-1:0]             ld;
  logic [LHI_W-1:0]            lhi;
  logic [PHI_W-1:0]            phi;
  logic [W:0]                  lt, pt;
  logic                        lge, pge, pact;

  // dividend split: high part gives saturation test and starting remainder
  assign ld  = LD_W'(lvl_sum_i) << dal_pkg::FRAC_BITS;
  assign lhi = ld[LD_W-1:dal_pkg::AVG_W];
  assign phi = pln_sum_i[dal_pkg::PSUM_W-1:dal_pkg::PAVG_W];

  // one quotient bit per cycle for each divider
  assign lt   = {lrem_q, ldiv_q[dal_pkg::AVG_W-1]};
  assign lge  = lt >= {1'b0, div_q};
  assign pt   = {prem_q, pdiv_q[dal_pkg::PAVG_W-1]};
  assign pge  = pt >= {1'b0, div_q};
  assign pact = step_q < STP_W'(dal_pkg::PAVG_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STP_W'(dal_pkg::AVG_W - 1);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= count_i;
      lsat_q <= lhi >= LHI_W'(count_i);
      psat_q <= phi >= PHI_W'(count_i);
      lrem_q <= lhi[W-1:0];
      prem_q <= phi[W-1:0];
      ldiv_q <= ld[dal_pkg::AVG_W-1:0];
      pdiv_q <= pln_sum_i[dal_pkg::PAVG_W-1:0];
      lq_q   <= '0;
      pq_q   <= '0;
    end else if (busy_q) begin
      lrem_q <= lge ? W'(lt - {1'b0, div_q}) : lt[W-1:0];
      ldiv_q <= ldiv_q << 1;
      lq_q   <= {lq_q[dal_pkg::AVG_W-2:0], lge};
      if (pact) begin
        prem_q <= pge ? W'(pt - {1'b0, div_q}) : pt[W-1:0];
        pdiv_q <= pdiv_q << 1;
        pq_q   <= {pq_q[dal_pkg::PAVG_W-2:0], pge};
      end
    end
  end

  assign done_o    = done_q;
  assign lvl_avg_o = lsat_q ? '1 : lq_q;
  assign pln_avg_o = psat_q ? '1 : pq_q;

endmodule

// ----- rtl/dal_outq.sv -----
module dal_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dal_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output dal_pkg::result_t data_o
);

  dal_pkg::result_t buf_q [4];
  logic [1:0]       wr_q, rd_q;
  logic [2:0]       cnt_q;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign data_o  = buf_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_q] <= data_i;
  end

endmodule

// ----- rtl/dal_core.sv -----
module dal_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dal_pkg::NCH_W-1:0]   channel_count_i,
  input  logic [dal_pkg::CFG_W-1:0]   max_interval_i,
  input  logic                        valid_i,
  input  dal_pkg::item_t              item_i,
  output logic                        pop_o,
  output logic                        res_push_o,
  output dal_pkg::result_t            res_o,
  input  logic                        res_full_i,
  output logic                        busy_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDATA  = 4'd2;
  localparam logic [3:0] ST_DSTART = 4'd3;
  localparam logic [3:0] ST_DWAIT  = 4'd4;
  localparam logic [3:0] ST_FIN    = 4'd5;
  localparam logic [3:0] ST_CP_A   = 4'd6;
  localparam logic [3:0] ST_CP_B   = 4'd7;
  localparam logic [3:0] ST_CP_W   = 4'd8;

  localparam int NCH = dal_pkg::NCH_W;
  localparam int RC  = dal_pkg::RC_W;
  localparam int IV  = dal_pkg::IVL_W;
  localparam int AW  = dal_pkg::MEM_AW;
  localparam int DW  = dal_pkg::MEM_DW;

  logic [3:0]                   state_q, state_d;
  logic [dal_pkg::LSUM_W-1:0]   lsum_q [dal_pkg::CHANNELS];
  logic [dal_pkg::PSUM_W-1:0]   psum_q [dal_pkg::CHANNELS];
  logic [dal_pkg::UCNT_W-1:0]   ucnt_q;
  logic [dal_pkg::TS_W-1:0]     ws_q;
  logic [IV-1:0]                ivl_q;
  logic [RC-1:0]                rc_q;
  logic [AW-1:0]                clr_q;
  logic [NCH-1:0]               c_q;
  logic [dal_pkg::SLOT_W-1:0]   slot_q;
  logic                         compact_q;
  logic [dal_pkg::HALF_W-1:0]   cpk_q;
  logic [NCH-1:0]               cpc_q;
  logic [DW-1:0]                hold_q;
  logic [dal_pkg::SLOT_W-1:0]   rd_slot_q;
  logic [dal_pkg::CH_W-1:0]     rd_ch_q;

  logic [DW-1:0]                mem_q [dal_pkg::MEM_DEPTH];
  logic [DW-1:0]                rdata_q;
  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic [DW-1:0]                wdata;

  logic [NCH-1:0]               nch;
  logic [dal_pkg::CH_W-1:0]     idx;
  logic [dal_pkg::LSUM_W:0]     lacc;
  logic [dal_pkg::PSUM_W:0]     pacc;
  logic                         acc_en, is_sample, close;
  logic [dal_pkg::UCNT_W-1:0]   ucnt_inc;
  logic [RC-1:0]                rc_inc;
  logic [IV:0]                  ivl_dbl;
  logic [IV-1:0]                ivl_next;
  logic                         div_start, div_done;
  logic [dal_pkg::AVG_W-1:0]    div_la;
  logic [dal_pkg::PAVG_W-1:0]   div_pa;
  logic [dal_pkg::AVG_W:0]      cp_l;
  logic [dal_pkg::PAVG_W:0]     cp_p;
  logic                         dwait_go, last_ch, last_cp;

  // active channels
  assign nch = (channel_count_i > NCH'(dal_pkg::CHANNELS)) ? NCH'(dal_pkg::CHANNELS)
                                                           : channel_count_i;

  // one sum read port: item channel while idle, close channel otherwise
  assign idx  = (state_q == ST_IDLE) ? item_i.channel : c_q[dal_pkg::CH_W-1:0];
  assign lacc = {1'b0, lsum_q[idx]} + (dal_pkg::LSUM_W + 1)'(item_i.lvl_ship);
  assign pacc = {1'b0, psum_q[idx]} + (dal_pkg::PSUM_W + 1)'(item_i.planet);

  assign is_sample = (state_q == ST_IDLE) && valid_i && (item_i.cmd == dal_pkg::CMD_SAMPLE);
  assign acc_en    = is_sample && ({1'b0, item_i.channel} < nch);
  assign ucnt_inc  = (ucnt_q == '1) ? ucnt_q : ucnt_q + 1'b1;
  assign close     = is_sample && item_i.eou &&
                     ({1'b0, item_i.timestamp} >
                      ({1'b0, ws_q} + (dal_pkg::TS_W + 1)'(ivl_q)));

  // window bookkeeping that a close settles up front
  assign rc_inc   = rc_q + 1'b1;
  assign ivl_dbl  = {ivl_q, 1'b0};
  assign ivl_next = (ivl_q < IV'(max_interval_i))
                    ? (ivl_dbl[IV] ? '1 : ivl_dbl[IV-1:0]) : ivl_q;

  assign dwait_go = (state_q == ST_DWAIT) && div_done && !res_full_i;
  assign last_ch  = (c_q + 1'b1) == nch;
  assign last_cp  = cpk_q == '1;

  // pairwise average for compaction
  assign cp_l = ({1'b0, hold_q[DW-1:dal_pkg::PAVG_W]} +
                 {1'b0, rdata_q[DW-1:dal_pkg::PAVG_W]}) >> 1;
  assign cp_p = ({1'b0, hold_q[dal_pkg::PAVG_W-1:0]} +
                 {1'b0, rdata_q[dal_pkg::PAVG_W-1:0]}) >> 1;

  assign pop_o     = (state_q == ST_IDLE) && valid_i;
  assign div_start = (state_q == ST_DSTART);
  assign busy_o    = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (valid_i && item_i.cmd == dal_pkg::CMD_READ) state_d = ST_RDATA;
        else if (close) state_d = (nch == '0) ? ST_FIN : ST_DSTART;
      end
      ST_RDATA:  if (!res_full_i) state_d = ST_IDLE;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (dwait_go) state_d = last_ch ? ST_FIN : ST_DSTART;
      ST_FIN:    state_d = (compact_q && nch != '0) ? ST_CP_A : ST_IDLE;
      ST_CP_A:   state_d = ST_CP_B;
      ST_CP_B:   state_d = ST_CP_W;
      ST_CP_W: begin
        if ((cpc_q + 1'b1) == nch && last_cp) state_d = ST_IDLE;
        else state_d = ST_CP_A;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // record store port control
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    re    = 1'b0;
    raddr = {item_i.read_slot, item_i.channel};
    case (state_q)
      ST_CLEAR: we = 1'b1;
      ST_IDLE:  re = valid_i && (item_i.cmd == dal_pkg::CMD_READ);
      ST_DWAIT: begin
        we    = dwait_go;
        waddr = {slot_q, c_q[dal_pkg::CH_W-1:0]};
        wdata = {div_la, div_pa};
      end
      ST_CP_A: begin
        re    = 1'b1;
        raddr = {cpk_q, 1'b0, cpc_q[dal_pkg::CH_W-1:0]};
      end
      ST_CP_B: begin
        re    = 1'b1;
        raddr = {cpk_q, 1'b1, cpc_q[dal_pkg::CH_W-1:0]};
      end
      ST_CP_W: begin
        we    = 1'b1;
        waddr = {1'b0, cpk_q, cpc_q[dal_pkg::CH_W-1:0]};
        wdata = {cp_l[dal_pkg::AVG_W-1:0], cp_p[dal_pkg::PAVG_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ucnt_q    <= '0;
      ws_q      <= '0;
      ivl_q     <= dal_pkg::INIT_INTERVAL;
      rc_q      <= '0;
      clr_q     <= '0;
      c_q       <= '0;
      compact_q <= 1'b0;
      cpk_q     <= '0;
      cpc_q     <= '0;
      for (int i = 0; i < dal_pkg::CHANNELS; i++) begin
        lsum_q[i] <= '0;
        psum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (acc_en) begin
        lsum_q[idx] <= lacc[dal_pkg::LSUM_W] ? '1 : lacc[dal_pkg::LSUM_W-1:0];
        psum_q[idx] <= pacc[dal_pkg::PSUM_W] ? '1 : pacc[dal_pkg::PSUM_W-1:0];
      end
      if (is_sample && item_i.eou) ucnt_q <= ucnt_inc;
      if (close) begin
        ws_q <= item_i.timestamp;
        c_q  <= '0;
        if (rc_inc >= RC'(dal_pkg::RECORDS)) begin
          rc_q      <= rc_inc >> 1;
          ivl_q     <= ivl_next;
          compact_q <= 1'b1;
        end else begin
          rc_q      <= rc_inc;
          compact_q <= 1'b0;
        end
      end
      if (dwait_go) begin
        lsum_q[idx] <= '0;
        psum_q[idx] <= '0;
        c_q         <= c_q + 1'b1;
      end
      if (state_q == ST_FIN) begin
        ucnt_q <= '0;
        cpk_q  <= '0;
        cpc_q  <= '0;
      end
      if (state_q == ST_CP_W) begin
        if ((cpc_q + 1'b1) == nch) begin
          cpc_q <= '0;
          cpk_q <= cpk_q + 1'b1;
        end else begin
          cpc_q <= cpc_q + 1'b1;
        end
      end
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (close) slot_q <= rc_q[dal_pkg::SLOT_W-1:0];
    if (state_q == ST_IDLE) begin
      rd_slot_q <= item_i.read_slot;
      rd_ch_q   <= item_i.channel;
    end
    if (state_q == ST_CP_B) hold_q <= rdata_q;
  end

  dal_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .lvl_sum_i (lsum_q[idx]),
    .pln_sum_i (psum_q[idx]),
    .count_i   (ucnt_q),
    .done_o    (div_done),
    .lvl_avg_o (div_la),
    .pln_avg_o (div_pa)
  );

  // result word
  always_comb begin
    res_push_o         = 1'b0;
    res_o.slot         = rd_slot_q;
    res_o.channel      = rd_ch_q;
    res_o.level_avg    = rdata_q[DW-1:dal_pkg::PAVG_W];
    res_o.planet_avg   = rdata_q[dal_pkg::PAVG_W-1:0];
    res_o.records_used = rc_q;
    res_o.interval     = ivl_q;
    res_o.last         = 1'b1;
    if (state_q == ST_RDATA) begin
      res_push_o = !res_full_i;
    end else if (state_q == ST_DWAIT) begin
      res_push_o       = dwait_go;
      res_o.slot       = slot_q;
      res_o.channel    = c_q[dal_pkg::CH_W-1:0];
      res_o.level_avg  = div_la;
      res_o.planet_avg = div_pa;
      res_o.last       = last_ch;
    end
  end

endmodule

// ----- rtl/decimating_average_logger.sv -----
// Multi-channel averaging history logger.
// Input side is a queue: a word is taken when push is high and full is low.
// A sample word adds level plus ships and planets into its channel's sums;
// the word with end_of_update set counts one update and may close the window.
// A close divides each active channel's sums by the update count, stores one
// record and emits one result word per active channel, last_of_run on the last.
// A read word returns one stored value as a single result word.
// Result side is a queue: the oldest word shows while empty is low and leaves
// when pop is high. A stalled receiver fills a four-word result queue and then
// holds the back end; a two-word queue still takes input meanwhile.
// A sample that does not close is settled in the back end's idle state; a read
// also passes through the read-data state. A close works on each active channel
// in turn, bound by the shared bit-serial divider (25 quotient steps). A close
// that fills the store adds a compaction pass over each active channel and record
// pair (32 pairs), bound by the single read port of the record store.
// After reset all 1024 entries of the record store are zeroed; full stays high
// once the input queue holds two words. Configuration writes act at once.
module decimating_average_logger (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dal_pkg::CFGI_W-1:0]   cfg_idx_i,
  input  logic [dal_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [dal_pkg::TS_W-1:0]     timestamp_i,
  input  logic [dal_pkg::CH_W-1:0]     channel_i,
  input  logic [dal_pkg::VAL_W-1:0]    level_value_i,
  input  logic [dal_pkg::VAL_W-1:0]    ship_count_i,
  input  logic [dal_pkg::VAL_W-1:0]    planet_count_i,
  input  logic                         end_of_update_i,
  input  logic [dal_pkg::SLOT_W-1:0]   read_slot_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [dal_pkg::SLOT_W-1:0]   record_slot_o,
  output logic [dal_pkg::CH_W-1:0]     out_channel_o,
  output logic [dal_pkg::AVG_W-1:0]    level_average_o,
  output logic [dal_pkg::PAVG_W-1:0]   planet_average_o,
  output logic [dal_pkg::RC_W-1:0]     records_used_o,
  output logic [dal_pkg::IVL_W-1:0]    current_interval_o,
  output logic                         last_of_run_o
);

  logic [dal_pkg::NCH_W-1:0] channel_count_q;
  logic [dal_pkg::CFG_W-1:0] max_interval_q;
  logic                      item_valid, item_pop;
  dal_pkg::item_t            item;
  logic                      res_push, res_full, core_busy;
  dal_pkg::result_t          res_in, res_out;

  // configuration registers; the starting interval only matters at reset,
  // where it returns to its reset value, so it is not kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= dal_pkg::CH_COUNT_RST;
      max_interval_q  <= dal_pkg::MAX_IVL_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dal_pkg::CFG_CHANNEL_COUNT)
        channel_count_q <= cfg_data_i[dal_pkg::NCH_W-1:0];
      if (cfg_idx_i == dal_pkg::CFG_MAX_INTERVAL)
        max_interval_q <= cfg_data_i;
    end
  end

  dal_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .timestamp_i     (timestamp_i),
    .channel_i       (channel_i),
    .level_value_i   (level_value_i),
    .ship_count_i    (ship_count_i),
    .planet_count_i  (planet_count_i),
    .end_of_update_i (end_of_update_i),
    .read_slot_i     (read_slot_i),
    .valid_o         (item_valid),
    .item_o          (item),
    .pop_i           (item_pop)
  );

  dal_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (channel_count_q),
    .max_interval_i  (max_interval_q),
    .valid_i         (item_valid),
    .item_i          (item),
    .pop_o           (item_pop),
    .res_push_o      (res_push),
    .res_o           (res_in),
    .res_full_i      (res_full),
    .busy_o          (core_busy)
  );

  dal_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign record_slot_o      = res_out.slot;
  assign out_channel_o      = res_out.channel;
  assign level_average_o    = res_out.level_avg;
  assign planet_average_o   = res_out.planet_avg;
  assign records_used_o     = res_out.records_used;
  assign current_interval_o = res_out.interval;
  assign last_of_run_o      = res_out.last;

  // back end never writes into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result written into full queue");

  // back end only takes a word while idle and one is waiting
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> (item_valid && !core_busy))
    else $error("word taken while none waiting or back end busy");

  // a result is only produced while the back end is working on a word
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> core_busy)
    else $error("result produced while back end idle");

  // stored record count stays within the store
  a_rc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_in.records_used < dal_pkg::RC_W'(dal_pkg::RECORDS)))
    else $error("record count out of range");

endmodule

// ----- sim/tb_decimating_average_logger.sv -----
`timescale 1ns / 1ps

module tb_decimating_average_logger;

  localparam logic [dal_pkg::CFGI_W-1:0] CFG_INITIAL_INTERVAL = dal_pkg::CFGI_W'(1);
  localparam int DRAIN_CYCLES = 3000;

  // predictor of the logger with its own copy of state and registers
  class history_scoreboard;
    bit [dal_pkg::NCH_W-1:0]  chan_count = dal_pkg::CH_COUNT_RST;
    bit [dal_pkg::CFG_W-1:0]  max_ivl = dal_pkg::MAX_IVL_RST;
    bit [dal_pkg::LSUM_W-1:0] level_sum[dal_pkg::CHANNELS];
    bit [dal_pkg::PSUM_W-1:0] planet_sum[dal_pkg::CHANNELS];
    bit [dal_pkg::UCNT_W-1:0] updates;
    bit [dal_pkg::TS_W-1:0]   win_start;
    bit [dal_pkg::IVL_W-1:0]  ivl = dal_pkg::INIT_INTERVAL;
    bit [dal_pkg::RC_W-1:0]   rec_count;
    bit [dal_pkg::AVG_W-1:0]  level_store[dal_pkg::RECORDS][dal_pkg::CHANNELS];
    bit [dal_pkg::PAVG_W-1:0] planet_store[dal_pkg::RECORDS][dal_pkg::CHANNELS];
    dal_pkg::result_t         expected_words[$];
    int                       errors;

    function int active_channels();
      return (chan_count > dal_pkg::CHANNELS) ? dal_pkg::CHANNELS : int'(chan_count);
    endfunction

    function void write_reg(bit [dal_pkg::CFGI_W-1:0] idx, bit [dal_pkg::CFG_W-1:0] data);
      if (idx == dal_pkg::CFG_CHANNEL_COUNT) chan_count = data[dal_pkg::NCH_W-1:0];
      else if (idx == dal_pkg::CFG_MAX_INTERVAL) max_ivl = data;
    endfunction

    // pairwise averaging of the full store, interval doubles below the max
    function void compact_store(int nch);
      int k;
      bit [31:0] dbl;
      k = 0;
      for (int j = 0; j + 1 < rec_count; j += 2) begin
        for (int c = 0; c < nch; c++) begin
          level_store[k][c] =
            dal_pkg::AVG_W'(({1'b0, level_store[j][c]} + level_store[j+1][c]) >> 1);
          planet_store[k][c] =
            dal_pkg::PAVG_W'(({1'b0, planet_store[j][c]} + planet_store[j+1][c]) >> 1);
        end
        k++;
      end
      rec_count = rec_count / 2;
      if (ivl < max_ivl) begin
        dbl = 32'(ivl) * 2;
        ivl = (dbl > 32'h1FFFF) ? 17'h1FFFF : dbl[dal_pkg::IVL_W-1:0];
      end
    endfunction

    function void note_word(dal_pkg::cmd_e cmd, bit [dal_pkg::TS_W-1:0] ts,
                            bit [dal_pkg::CH_W-1:0] ch, bit [dal_pkg::VAL_W-1:0] lvl,
                            bit [dal_pkg::VAL_W-1:0] shp, bit [dal_pkg::VAL_W-1:0] pln,
                            bit eou, bit [dal_pkg::SLOT_W-1:0] rs);
      int nch;
      longint unsigned s, la, pa;
      dal_pkg::result_t r;
      dal_pkg::result_t run[$];
      nch = active_channels();
      if (cmd == dal_pkg::CMD_READ) begin
        r = '{slot: rs, channel: ch, level_avg: level_store[rs][ch],
              planet_avg: planet_store[rs][ch], records_used: rec_count,
              interval: ivl, last: 1'b1};
        expected_words.push_back(r);
        return;
      end
      if (ch < nch) begin
        s = longint'(level_sum[ch]) + lvl + shp;
        level_sum[ch] = (s > 64'hFFFF_FFFF_FFFF) ? '1 : s[dal_pkg::LSUM_W-1:0];
        s = longint'(planet_sum[ch]) + pln;
        planet_sum[ch] = (s > 64'hFFFF_FFFF) ? '1 : s[dal_pkg::PSUM_W-1:0];
      end
      if (!eou) return;
      if (updates != '1) updates++;
      if (longint'(ts) <= longint'(win_start) + ivl) return;
      // window close: one word per active channel
      for (int c = 0; c < nch; c++) begin
        la = 0;
        pa = 0;
        if (updates != 0) begin
          la = (longint'(level_sum[c]) << dal_pkg::FRAC_BITS) / updates;
          if (la > 64'h1FF_FFFF) la = 64'h1FF_FFFF;
          pa = longint'(planet_sum[c]) / updates;
          if (pa > 64'hFFFF) pa = 64'hFFFF;
        end
        if (rec_count < dal_pkg::RECORDS) begin
          level_store[rec_count][c] = la[dal_pkg::AVG_W-1:0];
          planet_store[rec_count][c] = pa[dal_pkg::PAVG_W-1:0];
        end
        level_sum[c] = '0;
        planet_sum[c] = '0;
        r = '{slot: rec_count[dal_pkg::SLOT_W-1:0], channel: dal_pkg::CH_W'(c),
              level_avg: la[dal_pkg::AVG_W-1:0], planet_avg: pa[dal_pkg::PAVG_W-1:0],
              records_used: '0, interval: '0, last: 1'b0};
        run.push_back(r);
      end
      if (rec_count < dal_pkg::RECORDS) rec_count++;
      win_start = ts;
      updates = '0;
      if (rec_count >= dal_pkg::RECORDS) compact_store(nch);
      foreach (run[i]) begin
        run[i].records_used = rec_count;
        run[i].interval = ivl;
        run[i].last = (i == run.size() - 1);
        expected_words.push_back(run[i]);
      end
    endfunction

    function void check_word(dal_pkg::result_t got);
      dal_pkg::result_t exp;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
        return;
      end
      exp = expected_words.pop_front();
      if (got.slot !== exp.slot || got.channel !== exp.channel ||
          got.level_avg !== exp.level_avg || got.planet_avg !== exp.planet_avg ||
          got.records_used !== exp.records_used || got.interval !== exp.interval ||
          got.last !== exp.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch expected: %p", exp);
          $display("mismatch actual:   %p", got);
        end
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [dal_pkg::CFGI_W-1:0]  cfg_idx_i;
  logic [dal_pkg::CFG_W-1:0]   cfg_data_i;
  logic                        push;
  logic                        full;
  logic                        command_i;
  logic [dal_pkg::TS_W-1:0]    timestamp_i;
  logic [dal_pkg::CH_W-1:0]    channel_i;
  logic [dal_pkg::VAL_W-1:0]   level_value_i;
  logic [dal_pkg::VAL_W-1:0]   ship_count_i;
  logic [dal_pkg::VAL_W-1:0]   planet_count_i;
  logic                        end_of_update_i;
  logic [dal_pkg::SLOT_W-1:0]  read_slot_i;
  logic                        empty;
  logic                        pop;
  logic [dal_pkg::SLOT_W-1:0]  record_slot_o;
  logic [dal_pkg::CH_W-1:0]    out_channel_o;
  logic [dal_pkg::AVG_W-1:0]   level_average_o;
  logic [dal_pkg::PAVG_W-1:0]  planet_average_o;
  logic [dal_pkg::RC_W-1:0]    records_used_o;
  logic [dal_pkg::IVL_W-1:0]   current_interval_o;
  logic                        last_of_run_o;

  history_scoreboard sb;
  bit gaps_on;
  int pop_pct;

  decimating_average_logger dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_decimating_average_logger failed");
    $finish;
  end

  // receiver: check accepted words, stall on a changing duty pattern
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_word('{slot: record_slot_o, channel: out_channel_o,
                      level_avg: level_average_o, planet_avg: planet_average_o,
                      records_used: records_used_o, interval: current_interval_o,
                      last: last_of_run_o});
    pop <= ($urandom_range(0, 99) < pop_pct);
  end

  // pop duty is redrawn at random from four settings
  initial begin
    pop_pct = 100;
    forever begin
      repeat (150) @(posedge clk_i);
      case ($urandom_range(0, 3))
        0: pop_pct = 100;
        1: pop_pct = 70;
        2: pop_pct = 25;
        default: pop_pct = 5;
      endcase
    end
  end

  // push one word and wait for it to be taken
  task automatic send_word(dal_pkg::cmd_e cmd, bit [dal_pkg::TS_W-1:0] ts,
                           bit [dal_pkg::CH_W-1:0] ch, bit [dal_pkg::VAL_W-1:0] lvl,
                           bit [dal_pkg::VAL_W-1:0] shp, bit [dal_pkg::VAL_W-1:0] pln,
                           bit eou, bit [dal_pkg::SLOT_W-1:0] rs);
    push            <= 1'b1;
    command_i       <= cmd;
    timestamp_i     <= ts;
    channel_i       <= ch;
    level_value_i   <= lvl;
    ship_count_i    <= shp;
    planet_count_i  <= pln;
    end_of_update_i <= eou;
    read_slot_i     <= rs;
    do @(posedge clk_i); while (full !== 1'b0);
    sb.note_word(cmd, ts, ch, lvl, shp, pln, eou, rs);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // register write once all words are out and the back end has settled
  task automatic write_reg(bit [dal_pkg::CFGI_W-1:0] idx, bit [dal_pkg::CFG_W-1:0] data);
    push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [dal_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return dal_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // mostly well-formed updates, some reads, some stray samples
  task automatic run_phase(int n);
    int cnt, k, nch;
    bit [dal_pkg::CH_W-1:0] ch;
    bit [dal_pkg::TS_W-1:0] ts;
    cnt = 0;
    while (cnt < n) begin
      nch = sb.active_channels();
      case ($urandom_range(0, 9))
        0, 1: begin
          send_word(dal_pkg::CMD_READ, $urandom, dal_pkg::CH_W'($urandom), pick_value(),
                    pick_value(), pick_value(), 1'($urandom),
                    dal_pkg::SLOT_W'($urandom));
          cnt++;
        end
        2: begin
          send_word(dal_pkg::CMD_SAMPLE, $urandom, dal_pkg::CH_W'($urandom), pick_value(),
                    pick_value(), pick_value(), 1'($urandom),
                    dal_pkg::SLOT_W'($urandom));
          cnt++;
        end
        default: begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) begin
            if (nch > 0 && $urandom_range(0, 4) != 0)
              ch = dal_pkg::CH_W'($urandom_range(0, nch - 1));
            else ch = dal_pkg::CH_W'($urandom);
            if (i == k - 1) begin
              if ($urandom_range(0, 3) != 0)
                ts = sb.win_start + sb.ivl + 1 + $urandom_range(0, 32);
              else
                ts = sb.win_start + $urandom_range(0, sb.ivl);
            end else begin
              ts = $urandom;
            end
            send_word(dal_pkg::CMD_SAMPLE, ts, ch, pick_value(), pick_value(),
                      pick_value(), (i == k - 1), dal_pkg::SLOT_W'($urandom));
            cnt++;
          end
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    gaps_on         = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    push            = 1'b0;
    pop             = 1'b0;
    command_i       = dal_pkg::CMD_SAMPLE;
    timestamp_i     = '0;
    channel_i       = '0;
    level_value_i   = '0;
    ship_count_i    = '0;
    planet_count_i  = '0;
    end_of_update_i = 1'b0;
    read_slot_i     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads of empty store, extremes, inactive channel, window edge
    send_word(dal_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
    send_word(dal_pkg::CMD_READ, '1, '1, '1, '1, '1, 1, '1);
    send_word(dal_pkg::CMD_SAMPLE, 0, 0, '1, '1, '1, 0, 0);
    send_word(dal_pkg::CMD_SAMPLE, 0, 1, 0, 0, 0, 0, 0);
    send_word(dal_pkg::CMD_SAMPLE, 0, 15, 16'h1234, 16'h4321, 16'h0F0F, 0, 0);
    send_word(dal_pkg::CMD_SAMPLE, 24, 3, 16'h00FF, 16'h0001, 16'h0002, 1, 0);
    send_word(dal_pkg::CMD_SAMPLE, '1, 2, 16'h8000, 16'h8000, 16'hFFFF, 0, '1);
    send_word(dal_pkg::CMD_SAMPLE, 25, 0, 16'h0003, 0, 16'h0007, 1, 0);
    send_word(dal_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
    send_word(dal_pkg::CMD_READ, 0, 3, 0, 0, 0, 0, 0);
    send_word(dal_pkg::CMD_READ, 0, 15, 0, 0, 0, 0, 0);
    send_word(dal_pkg::CMD_SAMPLE, 60, 1, '1, 0, '1, 1, 0);
    send_word(dal_pkg::CMD_READ, 0, 1, 0, 0, 0, 0, 1);

    // random phases over several settings
    gaps_on = 1'b1;
    write_reg(dal_pkg::CFG_CHANNEL_COUNT, 16);
    write_reg(dal_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
    write_reg(CFG_INITIAL_INTERVAL, 1);
    run_phase(40);
    write_reg(dal_pkg::CFG_CHANNEL_COUNT, 1);
    write_reg(dal_pkg::CFG_MAX_INTERVAL, 1);
    gaps_on = 1'b0;
    run_phase(90);
    write_reg(dal_pkg::CFG_CHANNEL_COUNT, 0);
    write_reg(dal_pkg::CFG_MAX_INTERVAL, 43200);
    gaps_on = 1'b1;
    run_phase(25);
    write_reg(dal_pkg::CFG_CHANNEL_COUNT, 31);
    write_reg(dal_pkg::CFG_MAX_INTERVAL, 2);
    write_reg(CFG_INITIAL_INTERVAL, 16'hFFFF);
    run_phase(40);
    write_reg(dal_pkg::CFG_CHANNEL_COUNT, 4);
    write_reg(dal_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
    run_phase(35);

    // last close at the top of the time range
    send_word(dal_pkg::CMD_SAMPLE, '1, 0, 16'h0101, 16'h0202, 16'h0303, 1, 0);
    push <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0)
      $display("tb_decimating_average_logger passed");
    else
      $display("tb_decimating_average_logger failed");
    $finish;
  end

endmodule
